[rtl/mma_pkg.sv]
// shared types and codes of the matrix multiply / add engine
// no dependencies; imported by mma_ctrl, mma_mac, the top level and the checker
package mma_pkg;

    // width of the row and column fields on the ports
    localparam int IDX_PORT_W = 3;

    // request kinds carried in tuser
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_A_ROWS  = 3'd0;
    localparam logic [2:0] CFG_A_COLS  = 3'd1;
    localparam logic [2:0] CFG_B_ROWS  = 3'd2;
    localparam logic [2:0] CFG_B_COLS  = 3'd3;
    localparam logic [2:0] CFG_OP_MODE = 3'd4;

    // operating modes
    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAIT = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    // one memory read issued by the sequencer, travels with the read data
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last_k;
        logic                  last_elem;
        logic                  err;
        logic                  mode;
        logic [IDX_PORT_W-1:0] row;
        logic [IDX_PORT_W-1:0] col;
    } mac_tag_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } mac_status_t;

endpackage

[rtl/mma_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module mma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mma_ctrl.sv]
// request intake, configuration registers and element sequencer
// depends on mma_pkg; drives the store memories and the mac tag
module mma_ctrl
    import mma_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [3:0]                          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          in_req,
    input  logic [IDX_PORT_W-1:0]               in_row,
    input  logic [IDX_PORT_W-1:0]               in_col,
    input  logic [ELEM_WIDTH-1:0]               in_value,
    output logic                                a_we,
    output logic                                b_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  waddr,
    output logic [ELEM_WIDTH-1:0]               wdata,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  a_raddr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  b_raddr,
    output mac_tag_t                            tag,
    input  mac_status_t                         status
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);

    state_t           state_reg, state_next;
    logic [3:0]       a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic             op_mode_reg;
    logic             mode_reg, mode_next;
    logic             err_reg, err_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] row_lim_reg, row_lim_next;
    logic [IDX_W-1:0] col_lim_reg, col_lim_next;
    logic [IDX_W-1:0] k_lim_reg, k_lim_next;

    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] ar_lim, ac_lim, br_lim, bc_lim;
    logic             mismatch;
    logic             free;
    logic             last_k, last_elem;

    // dimension register to last index, zero counts as one, large values clamp
    function automatic logic [IDX_W-1:0] lim_of(input logic [3:0] v);
        if (v == 4'd0)
        begin
            return '0;
        end
        else if (v > 4'(MAX_DIM))
        begin
            return IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            return IDX_W'(v - 4'd1);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = ({1'b0, in_row} < 4'(MAX_DIM)) && ({1'b0, in_col} < 4'(MAX_DIM));

    assign a_we  = accept && (in_req == REQ_LOAD_A) && in_range;
    assign b_we  = accept && (in_req == REQ_LOAD_B) && in_range;
    assign waddr = addr_of(in_row[IDX_W-1:0], in_col[IDX_W-1:0]);
    assign wdata = in_value;

    assign ar_lim = lim_of(a_rows_reg);
    assign ac_lim = lim_of(a_cols_reg);
    assign br_lim = lim_of(b_rows_reg);
    assign bc_lim = lim_of(b_cols_reg);

    always_comb
    begin
        if (op_mode_reg == MODE_MUL)
        begin
            mismatch = (ac_lim != br_lim);
        end
        else
        begin
            mismatch = (ar_lim != br_lim) || (ac_lim != bc_lim);
        end
    end

    // the next element starts only once the mac and the output stage are empty
    assign free      = !status.pipe_busy && !status.out_full;
    assign last_k    = (k_reg == k_lim_reg);
    assign last_elem = last_k && (i_reg == row_lim_reg) && (j_reg == col_lim_reg);

    always_comb
    begin
        if (mode_reg == MODE_MUL)
        begin
            a_raddr = addr_of(i_reg, k_reg);
            b_raddr = addr_of(k_reg, j_reg);
        end
        else
        begin
            a_raddr = addr_of(i_reg, j_reg);
            b_raddr = addr_of(i_reg, j_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        err_next     = err_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        row_lim_next = row_lim_reg;
        col_lim_next = col_lim_reg;
        k_lim_next   = k_lim_reg;
        tag          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_req == REQ_START))
                begin
                    mode_next    = op_mode_reg;
                    err_next     = mismatch;
                    row_lim_next = ar_lim;
                    col_lim_next = (op_mode_reg == MODE_MUL) ? bc_lim : ac_lim;
                    k_lim_next   = (op_mode_reg == MODE_MUL) ? ac_lim : '0;
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                    state_next   = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (free)
                begin
                    if (err_reg)
                    begin
                        // mismatch request goes down the mac with a zero value
                        tag.valid     = 1'b1;
                        tag.first     = 1'b1;
                        tag.last_k    = 1'b1;
                        tag.last_elem = 1'b1;
                        tag.err       = 1'b1;
                        tag.mode      = mode_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                tag.valid     = 1'b1;
                tag.first     = (k_reg == '0);
                tag.last_k    = last_k;
                tag.last_elem = last_elem;
                tag.err       = 1'b0;
                tag.mode      = mode_reg;
                tag.row       = IDX_PORT_W'(i_reg);
                tag.col       = IDX_PORT_W'(j_reg);
                if (!last_k)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                        if (j_reg == col_lim_reg)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            a_rows_reg  <= 4'd1;
            a_cols_reg  <= 4'd1;
            b_rows_reg  <= 4'd1;
            b_cols_reg  <= 4'd1;
            op_mode_reg <= MODE_MUL;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_A_ROWS:  a_rows_reg  <= cfg_data;
                    CFG_A_COLS:  a_cols_reg  <= cfg_data;
                    CFG_B_ROWS:  b_rows_reg  <= cfg_data;
                    CFG_B_COLS:  b_cols_reg  <= cfg_data;
                    CFG_OP_MODE: op_mode_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        err_reg     <= err_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        row_lim_reg <= row_lim_next;
        col_lim_reg <= col_lim_next;
        k_lim_reg   <= k_lim_next;
    end

endmodule

[rtl/mma_mac.sv]
// shared multiply-accumulate unit with the result register
// depends on mma_pkg; fed by the store memories and the sequencer tag
module mma_mac
    import mma_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mac_tag_t              tag,
    input  logic [ELEM_WIDTH-1:0] a_rdata,
    input  logic [ELEM_WIDTH-1:0] b_rdata,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [IDX_PORT_W-1:0] out_row,
    output logic [IDX_PORT_W-1:0] out_col,
    output logic [31:0]           out_value,
    output logic                  out_last,
    output logic                  out_err,
    output mac_status_t           status
);

    mac_tag_t                     s1_tag_reg, s2_tag_reg;
    logic [31:0]                  s2_val_reg, s2_val_next;
    logic [31:0]                  acc_reg, acc_next;
    logic                         out_valid_reg, out_valid_next;
    logic [IDX_PORT_W-1:0]        out_row_reg, out_col_reg;
    logic [31:0]                  out_value_reg;
    logic                         out_last_reg, out_err_reg;

    logic signed [ELEM_WIDTH-1:0] a_s, b_s, acc_s;
    logic [31:0]                  a_x, b_x;

    // stage 1: sign-extend the read data, one multiply or one add
    assign a_s = a_rdata;
    assign b_s = b_rdata;
    assign a_x = 32'(a_s);
    assign b_x = 32'(b_s);

    always_comb
    begin
        if (s1_tag_reg.err)
        begin
            s2_val_next = '0;
        end
        else if (s1_tag_reg.mode == MODE_ADD)
        begin
            s2_val_next = a_x + b_x;
        end
        else
        begin
            s2_val_next = a_x * b_x;
        end
    end

    // stage 2: accumulate, wrap to the element width on the way out
    assign acc_next = (s2_tag_reg.first ? 32'd0 : acc_reg) + s2_val_reg;
    assign acc_s    = acc_next[ELEM_WIDTH-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s2_tag_reg.valid && s2_tag_reg.last_k)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg    <= '0;
            s2_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_tag_reg    <= tag;
            s2_tag_reg    <= s1_tag_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_val_reg <= s2_val_next;
        if (s2_tag_reg.valid)
        begin
            acc_reg <= acc_next;
            if (s2_tag_reg.last_k)
            begin
                out_row_reg   <= s2_tag_reg.row;
                out_col_reg   <= s2_tag_reg.col;
                out_value_reg <= 32'(acc_s);
                out_last_reg  <= s2_tag_reg.last_elem;
                out_err_reg   <= s2_tag_reg.err;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_row          = out_row_reg;
    assign out_col          = out_col_reg;
    assign out_value        = out_value_reg;
    assign out_last         = out_last_reg;
    assign out_err          = out_err_reg;
    assign status.pipe_busy = s1_tag_reg.valid || s2_tag_reg.valid;
    assign status.out_full  = out_valid_reg;

endmodule

[rtl/matrix_multiply_add_engine.sv]
// top level of the integer matrix multiply / add engine
// depends on mma_pkg, mma_ram, mma_ctrl and mma_mac
//
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tuser: req_type; tdata: row, col, value
// m_axis   out  m_axis_tvalid/tready       tuser: dim_error; tlast: is_last;
//                                          tdata: out_row, out_col, out_value
// cfg      in   cfg_we, one cycle          cfg_index, cfg_data
//
// a load request writes one entry of store a or store b
// a start request holds s_axis_tready low while it runs; each result element
// is built from n reads, n = a_cols in multiply mode and 1 in add mode, and goes
// through the one shared mac, the registered memory read and the result register
// reset clears the control state and sets the dimensions to 1, multiply mode;
// the stores hold no defined value until written
// a stall on m_axis holds the sequencer before it starts the next element;
// new requests are taken while the final result waits
module matrix_multiply_add_engine
    import mma_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index[2:0], col_index[5:3], elem_value[37:6]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // dim_error[0]
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                  a_we, b_we;
    logic [ADDR_W-1:0]     waddr, a_raddr, b_raddr;
    logic [ELEM_WIDTH-1:0] wdata, a_rdata, b_rdata;
    mac_tag_t              tag;
    mac_status_t           status;
    logic [IDX_PORT_W-1:0] out_row, out_col;
    logic [31:0]           out_value;
    logic                  out_err;

    mma_ctrl #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (s_axis_tuser),
        .in_row    (s_axis_tdata[2:0]),
        .in_col    (s_axis_tdata[5:3]),
        .in_value  (s_axis_tdata[6 +: ELEM_WIDTH]),
        .a_we      (a_we),
        .b_we      (b_we),
        .waddr     (waddr),
        .wdata     (wdata),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .tag       (tag),
        .status    (status)
    );

    mma_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mma_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mma_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_axis_tlast),
        .out_err   (out_err),
        .status    (status)
    );

    assign m_axis_tdata = {2'b00, out_value, out_col, out_row};
    assign m_axis_tuser = out_err;

endmodule

[rtl/mma_checker.sv]
// port-level checks of the matrix engine, bound to the top level
// depends on mma_pkg and matrix_multiply_add_engine
module mma_checker
    import mma_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a mismatch result is the only and final one, with zero row, column and value
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 40'd0))
        else $error("malformed dimension error result");

    // a start request closes the input until its elements are issued
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_START) |=> !s_axis_tready)
        else $error("input open right after a start request");

endmodule

bind matrix_multiply_add_engine mma_checker u_mma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/matrix_multiply_add_engine_tb.sv]
// self-checking testbench of matrix_multiply_add_engine: loads, start requests, config phases
// depends on mma_pkg and the engine rtl; the scoreboard class predicts every result element
module matrix_multiply_add_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mma_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int TOTAL_ITEMS  = 450;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int GRID         = 8;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               last;
        logic               err;
    } elem_t;

    class matrix_scoreboard;
        logic [3:0]         dim_reg [4];
        logic               mode_reg;
        logic signed [31:0] mat_a [GRID*GRID];
        logic signed [31:0] mat_b [GRID*GRID];
        elem_t              expected_elems [$];
        int                 errors;

        static function int clamp_dim(logic [3:0] v);
            if (v == 4'd0)
                return 1;
            if (v > GRID)
                return GRID;
            return int'(v);
        endfunction

        function void reset_regs();
            foreach (dim_reg[i])
                dim_reg[i] = 4'd1;
            mode_reg = MODE_MUL;
            errors   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [3:0] data);
            if (idx == CFG_OP_MODE)
                mode_reg = data[0];
            else if (idx < CFG_OP_MODE)
                dim_reg[idx] = data;
        endfunction

        function int pending();
            return expected_elems.size();
        endfunction

        // predicts what one accepted request produces
        function void note_request(logic [1:0] req, logic [2:0] row, logic [2:0] col,
                                   logic signed [31:0] val);
            int    ar, ac, br, bc, rows, cols;
            elem_t e;
            logic signed [31:0] acc;
            ar = clamp_dim(dim_reg[CFG_A_ROWS]);
            ac = clamp_dim(dim_reg[CFG_A_COLS]);
            br = clamp_dim(dim_reg[CFG_B_ROWS]);
            bc = clamp_dim(dim_reg[CFG_B_COLS]);
            if (req == REQ_LOAD_A)
                mat_a[row*GRID + col] = val;
            else if (req == REQ_LOAD_B)
                mat_b[row*GRID + col] = val;
            if (req != REQ_START)
                return;
            if ((mode_reg == MODE_MUL && ac != br) ||
                (mode_reg == MODE_ADD && (ar != br || ac != bc)))
            begin
                e = '{row: 3'd0, col: 3'd0, value: 32'sd0, last: 1'b1, err: 1'b1};
                expected_elems.push_back(e);
                return;
            end
            rows = ar;
            cols = (mode_reg == MODE_MUL) ? bc : ac;
            for (int i = 0; i < rows; i++)
            begin
                for (int j = 0; j < cols; j++)
                begin
                    acc = 32'sd0;
                    if (mode_reg == MODE_MUL)
                    begin
                        for (int k = 0; k < ac; k++)
                            acc = acc + mat_a[i*GRID + k] * mat_b[k*GRID + j];
                    end
                    else
                        acc = mat_a[i*GRID + j] + mat_b[i*GRID + j];
                    e.row   = 3'(i);
                    e.col   = 3'(j);
                    e.value = acc;
                    e.last  = (i == rows - 1) && (j == cols - 1);
                    e.err   = 1'b0;
                    expected_elems.push_back(e);
                end
            end
        endfunction

        function void check_element(logic [2:0] row, logic [2:0] col,
                                    logic signed [31:0] value, logic last, logic err);
            elem_t e;
            if (expected_elems.size() == 0)
            begin
                $display("%0t: unexpected result row %0d col %0d value %h last %b err %b",
                         $time, row, col, value, last, err);
                errors++;
                return;
            end
            e = expected_elems.pop_front();
            if (row !== e.row)
            begin
                $display("%0t: out_row expected %0d actual %0d", $time, e.row, row);
                errors++;
            end
            if (col !== e.col)
            begin
                $display("%0t: out_col expected %0d actual %0d", $time, e.col, col);
                errors++;
            end
            if (value !== e.value)
            begin
                $display("%0t: out_value (%0d,%0d) expected %h actual %h",
                         $time, e.row, e.col, e.value, value);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: is_last expected %b actual %b", $time, e.last, last);
                errors++;
            end
            if (err !== e.err)
            begin
                $display("%0t: dim_error expected %b actual %b", $time, e.err, err);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = CFG_A_ROWS;
    logic [3:0]  cfg_data      = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = REQ_LOAD_A;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    matrix_scoreboard sb = new;
    int  src_idle_pct  = 36;
    int  dst_idle_pct  = 62;
    int  rx_hold_cycles = 0;
    int  sent_items    = 0;
    int  cycle_count   = 0;
    bit  a_written [GRID*GRID];
    bit  b_written [GRID*GRID];

    matrix_multiply_add_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    function automatic logic [31:0] pick_value();
        logic [31:0] corner [5] = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1};
        if ($urandom_range(99) < 25)
            return corner[$urandom_range(4)];
        return $urandom;
    endfunction

    // mostly small sizes, a few zero, at the top and out of range
    function automatic logic [3:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 4'd0;
        if (r < 13)
            return 4'($urandom_range(9, 15));
        if (r < 22)
            return 4'($urandom_range(4, 8));
        return 4'($urandom_range(1, 3));
    endfunction

    task automatic send_item(logic [1:0] req, logic [2:0] row, logic [2:0] col,
                             logic [31:0] val);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, val, col, row};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(req, row, col, val);
        if (req == REQ_LOAD_A)
            a_written[row*GRID + col] = 1'b1;
        else if (req == REQ_LOAD_B)
            b_written[row*GRID + col] = 1'b1;
        if (req != REQ_UNUSED)
            sent_items++;
    endtask

    // the block must never read an entry that was not loaded
    task automatic start_compute();
        int ar, ac, br, bc;
        ar = matrix_scoreboard::clamp_dim(sb.dim_reg[CFG_A_ROWS]);
        ac = matrix_scoreboard::clamp_dim(sb.dim_reg[CFG_A_COLS]);
        br = matrix_scoreboard::clamp_dim(sb.dim_reg[CFG_B_ROWS]);
        bc = matrix_scoreboard::clamp_dim(sb.dim_reg[CFG_B_COLS]);
        for (int i = 0; i < ar; i++)
            for (int j = 0; j < ac; j++)
                if (!a_written[i*GRID + j])
                    send_item(REQ_LOAD_A, 3'(i), 3'(j), pick_value());
        for (int i = 0; i < br; i++)
            for (int j = 0; j < bc; j++)
                if (!b_written[i*GRID + j])
                    send_item(REQ_LOAD_B, 3'(i), 3'(j), pick_value());
        send_item(REQ_START, 3'($urandom_range(7)), 3'($urandom_range(7)), $urandom);
    endtask

    task automatic configure(logic [3:0] ar, logic [3:0] ac, logic [3:0] br,
                             logic [3:0] bc, logic [3:0] mode);
        logic [3:0] vals [5];
        vals = '{ar, ac, br, bc, mode};
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a load or an ignored request may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(3'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : timeout_watch
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : result_side
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_element(m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6],
                                 m_axis_tlast, m_axis_tuser[0]);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    initial
    begin : request_side
        logic [31:0] corner [8];
        logic [3:0]  ar, ac, br, bc, mode;
        logic [1:0]  kind;
        int          pick, rows, cols;
        bit          pressure_done;
        corner = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0,
                   32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678};
        pressure_done = 1'b0;
        sb.reset_regs();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one row of A times one column of B at the full inner size, corner values
        configure(4'd1, 4'd8, 4'd8, 4'd1, {3'b000, MODE_MUL});
        for (int k = 0; k < GRID; k++)
        begin
            send_item(REQ_LOAD_A, 3'd0, 3'(k), corner[k]);
            send_item(REQ_LOAD_B, 3'(k), 3'd0, corner[(k + 3) % GRID]);
        end
        send_item(REQ_UNUSED, 3'd7, 3'd7, 32'hffff_ffff);
        start_compute();
        // zero reads as one, above the maximum as the maximum
        configure(4'd0, 4'd15, 4'd15, 4'd0, {3'b111, MODE_MUL});
        start_compute();
        // add with signed overflow in the first element
        configure(4'd1, 4'd4, 4'd1, 4'd4, {3'b000, MODE_ADD});
        send_item(REQ_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
        start_compute();
        // mismatched dimensions in both modes
        configure(4'd2, 4'd3, 4'd2, 4'd3, {3'b000, MODE_MUL});
        start_compute();
        configure(4'd2, 4'd3, 4'd3, 4'd3, {3'b000, MODE_ADD});
        start_compute();

        while (sent_items < TOTAL_ITEMS)
        begin
            if (sent_items < TOTAL_ITEMS / 3)
            begin
                src_idle_pct = 36;
                dst_idle_pct = 62;
            end
            else if (sent_items < 2 * TOTAL_ITEMS / 3)
            begin
                src_idle_pct = 62;
                dst_idle_pct = 36;
            end
            else
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            ar   = pick_dim();
            ac   = pick_dim();
            br   = pick_dim();
            bc   = pick_dim();
            mode = {3'($urandom_range(7)), 1'($urandom_range(1))};
            if ($urandom_range(99) < 80)
            begin
                if (mode[0] == MODE_MUL)
                    br = ac;
                else
                begin
                    br = ar;
                    bc = ac;
                end
            end
            configure(ar, ac, br, bc, mode);
            // receiver stalls long while a start request keeps the input busy
            if (!pressure_done && src_idle_pct == 0)
            begin
                pressure_done  = 1'b1;
                rx_hold_cycles = HOLD_CYCLES;
                start_compute();
            end
            repeat ($urandom_range(20, 40))
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    start_compute();
                else if (pick < 15)
                    send_item(REQ_UNUSED, 3'($urandom_range(7)), 3'($urandom_range(7)),
                              $urandom);
                else
                begin
                    kind = ($urandom_range(1) == 0) ? REQ_LOAD_A : REQ_LOAD_B;
                    rows = matrix_scoreboard::clamp_dim(
                               sb.dim_reg[(kind == REQ_LOAD_A) ? CFG_A_ROWS : CFG_B_ROWS]);
                    cols = matrix_scoreboard::clamp_dim(
                               sb.dim_reg[(kind == REQ_LOAD_A) ? CFG_A_COLS : CFG_B_COLS]);
                    if ($urandom_range(99) < 70)
                        send_item(kind, 3'($urandom_range(rows - 1)),
                                  3'($urandom_range(cols - 1)), pick_value());
                    else
                        send_item(kind, 3'($urandom_range(7)), 3'($urandom_range(7)),
                                  pick_value());
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
